// File: rtl/crs_pkg.sv
// Package: constants, types and parity function shared by the CLTU receiver files.
package crs_pkg;

  localparam int unsigned BLOCK_BYTES = 7;
  localparam int unsigned BLOCK_W     = BLOCK_BYTES * 8;
  localparam int unsigned CNT_W       = $clog2(BLOCK_BYTES + 1);
  localparam int unsigned OUT_W       = 56;
  localparam int unsigned PAR_W       = 7;

  localparam logic [7:0]       SYNC_FIRST  = 8'hEB;
  localparam logic [7:0]       SYNC_SECOND = 8'h90;
  localparam logic [PAR_W-1:0] GEN_TAPS    = 7'h45;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_START = 2'd1,
    EV_BLOCK = 2'd2,
    EV_FAIL  = 2'd3
  } event_e;

  typedef struct packed {
    event_e           evt;
    logic [OUT_W-1:0] data;
  } result_t;

  // One byte through the (63,56) BCH parity register, MSB first.
  function automatic logic [PAR_W-1:0] parity_update(input logic [PAR_W-1:0] acc,
                                                     input logic [7:0]       b);
    logic [PAR_W-1:0] a;
    logic             fb;
    a = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = b[i] ^ a[PAR_W-1];
      a  = {a[PAR_W-2:0], 1'b0};
      if (fb) begin
        a = a ^ GEN_TAPS;
      end
    end
    return a;
  endfunction

  // Block store to output width: low bits kept, zero-extended when narrower.
  function automatic logic [OUT_W-1:0] to_out(input logic [BLOCK_W-1:0] store);
    logic [63:0] wide;
    wide = 64'(store);
    return wide[OUT_W-1:0];
  endfunction

endpackage

// File: rtl/crs_core.sv
// Receiver core: sync hunt, block collection and parity check, one byte per step.
module crs_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        rx_byte_i,
  output crs_pkg::result_t  res_o
);

  logic                              in_sync_q, in_sync_d;
  logic [crs_pkg::CNT_W-1:0]         cnt_q, cnt_d;
  logic [crs_pkg::PAR_W-1:0]         par_q, par_d;
  logic [crs_pkg::BLOCK_W-1:0]       store_q, store_d;
  logic [7:0]                        want;
  logic [7:0]                        expect_byte;

  always_comb begin
    in_sync_d   = in_sync_q;
    cnt_d       = cnt_q;
    par_d       = par_q;
    store_d     = store_q;
    res_o.evt   = crs_pkg::EV_NONE;
    res_o.data  = '0;
    want        = (cnt_q == '0) ? crs_pkg::SYNC_FIRST : crs_pkg::SYNC_SECOND;
    expect_byte = {~par_q, 1'b0};

    if (!in_sync_q) begin
      if (rx_byte_i == want && cnt_q == crs_pkg::CNT_W'(1)) begin
        in_sync_d = 1'b1;
        cnt_d     = '0;
        par_d     = '0;
        res_o.evt = crs_pkg::EV_START;
      end else if (rx_byte_i == want) begin
        cnt_d = crs_pkg::CNT_W'(1);
      end else begin
        // restart the match, counting this byte if it opens the sequence
        cnt_d = (rx_byte_i == crs_pkg::SYNC_FIRST) ? crs_pkg::CNT_W'(1) : '0;
      end
    end else if (cnt_q < crs_pkg::CNT_W'(crs_pkg::BLOCK_BYTES)) begin
      store_d = crs_pkg::BLOCK_W'({store_q, rx_byte_i});
      par_d   = crs_pkg::parity_update(par_q, rx_byte_i);
      cnt_d   = crs_pkg::CNT_W'(cnt_q + 1'b1);
    end else begin
      if (rx_byte_i == expect_byte) begin
        res_o.evt  = crs_pkg::EV_BLOCK;
        res_o.data = crs_pkg::to_out(store_q);
      end else begin
        res_o.evt = crs_pkg::EV_FAIL;
        in_sync_d = 1'b0;
      end
      cnt_d = '0;
      par_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sync_q <= 1'b0;
      cnt_q     <= '0;
      par_q     <= '0;
    end else if (step_i) begin
      in_sync_q <= in_sync_d;
      cnt_q     <= cnt_d;
      par_q     <= par_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      store_q <= store_d;
    end
  end

endmodule

// File: rtl/cltu_stream_receiver.sv
// Top level: CLTU byte-stream receiver with registered result channel.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, rx_byte_i         | sink
//  out     | out_valid_o, out_ready_i, event_res_o,    | source
//          | block_data_o                              |
//
// Every accepted byte yields exactly one result, registered and shown in the
// next cycle; the core state and the result register both update on the input transfer.
// Sustained rate is one byte per cycle; in_ready_o drops only while a
// result sits in the output register and out_ready_i is low.
// Reset returns the receiver to hunting with an empty output register.
module cltu_stream_receiver (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                rx_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                event_res_o,
  output logic [crs_pkg::OUT_W-1:0] block_data_o
);

  logic             out_valid_q, out_valid_d;
  crs_pkg::result_t res_d, res_q;
  logic             in_xfer;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  crs_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (in_xfer),
    .rx_byte_i (rx_byte_i),
    .res_o     (res_d)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_res_o  = res_q.evt;
  assign block_data_o = res_q.data;

endmodule

// File: rtl/crs_checker.sv
// Port-level checker for the CLTU receiver, bound to the top level.
module crs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic [7:0]                rx_byte_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [1:0]                event_res_o,
  input logic [crs_pkg::OUT_W-1:0] block_data_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_res_o)
                                    && $stable(block_data_o))
    else $error("result changed while stalled");

  // every input transfer shows its result in the next cycle
  a_result_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("missing result after input transfer");

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != crs_pkg::EV_BLOCK |-> block_data_o == '0)
    else $error("block data set without a valid block");

  // start event only completes on the second sync byte
  a_start_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && rx_byte_i != crs_pkg::SYNC_SECOND
      |=> event_res_o != crs_pkg::EV_START)
    else $error("start event on wrong byte");

  // parity byte always has bit 0 clear
  a_parity_lsb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && rx_byte_i[0] |=> event_res_o != crs_pkg::EV_BLOCK)
    else $error("block accepted with parity bit 0 set");

endmodule

bind cltu_stream_receiver crs_checker u_crs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .rx_byte_i    (rx_byte_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .event_res_o  (event_res_o),
  .block_data_o (block_data_o)
);
